// File: rtl/fcca_pkg.sv
package fcca_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W         = 12;
  localparam int CNT_W         = 12;
  localparam int ENTRY_W       = 28;
  localparam int SIZE_W        = IDX_W + 1;
  localparam int TABLE_LIMIT   = (TABLE_ENTRIES < (1 << IDX_W)) ? TABLE_ENTRIES : (1 << IDX_W);
  localparam int ADDR_W        = $clog2(TABLE_LIMIT);

  localparam logic [ENTRY_W-1:0] FIRST_ENTRY    = 28'h0FFFFF8;
  localparam logic [ENTRY_W-1:0] CHAIN_END_MARK = 28'hFFFFFFF;
  localparam logic [IDX_W-1:0]   FIRST_DATA     = 12'd2;
  localparam logic [IDX_W-1:0]   PTR_RESET      = 12'd2;
  localparam logic [IDX_W-1:0]   PTR_MAX        = 12'hFFF;
  localparam logic [IDX_W-1:0]   CIU_RESET      = 12'd4094;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDATA,
    S_SCAN1,
    S_SCAN2,
    S_EOC,
    S_LINK,
    S_DONE
  } state_t;

endpackage

// File: rtl/fcca_if.sv
interface fcca_req_if;
  import fcca_pkg::*;

  logic             valid;
  logic             ready;
  cmd_t             command;
  logic [CNT_W-1:0] alloc_count;
  logic [IDX_W-1:0] link_from;
  logic [IDX_W-1:0] read_index;

  modport source (output valid, command, alloc_count, link_from, read_index, input ready);
  modport sink (input valid, command, alloc_count, link_from, read_index, output ready);
endinterface

interface fcca_rsp_if;
  import fcca_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic [IDX_W-1:0]   head_cluster;
  logic [ENTRY_W-1:0] entry_value;

  modport source (output valid, status, head_cluster, entry_value, input ready);
  modport sink (input valid, status, head_cluster, entry_value, output ready);
endinterface

// File: rtl/fcca_ram.sv
module fcca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/fat32_cluster_chain_allocator.sv
// FAT32 cluster chain allocator. Keeps a 4096 x 28-bit allocation table in a
// single-port-write, single-port-read RAM and a next-allocate pointer. After
// reset the block clears the table, one entry a cycle, before in_req.ready
// rises; cfg writes are taken throughout. An allocate request walks the table
// twice through the one RAM read port, one entry a cycle: a counting pass from
// the pointer and, if enough free entries were found and the link is legal, a
// linking pass that writes each link as the next free entry is seen, then the
// end-of-chain mark and, for a nonzero link_from, the link to the new head. An
// illegal link ends the request after the counting pass, and too few free
// entries before the end of the usable table end it with a no-space status.
// The response sits in an output register, so the next request is taken while
// the previous response waits; the final cycle of a request stretches until
// that register is free.
module fat32_cluster_chain_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [fcca_pkg::IDX_W-1:0] cfg_wr_data,
  fcca_req_if.sink                   in_req,
  fcca_rsp_if.source                 out_rsp
);
  import fcca_pkg::*;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   ciu_r;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [SIZE_W-1:0]  addr_r, addr_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pidx_r, pidx_nxt;
  logic [CNT_W-1:0]   found_r, found_nxt;
  logic [IDX_W-1:0]   prev_r, prev_nxt;
  logic [IDX_W-1:0]   first_r, first_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   link_r, link_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [ENTRY_W-1:0] res_entry_r, res_entry_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r;
  logic [IDX_W-1:0]   out_first_r;
  logic [ENTRY_W-1:0] out_entry_r;
  logic               out_load;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [SIZE_W-1:0]  s_sum;
  logic [SIZE_W-1:0]  tbl_size;
  logic [IDX_W-1:0]   start_idx;
  logic               issue;
  logic               hit;
  logic [CNT_W-1:0]   found_inc;
  logic               last_hit;
  logic               link_ok;
  logic               rd_legal;

  function automatic logic is_legal(input logic [IDX_W-1:0] idx, input logic [SIZE_W-1:0] size);
    return (idx >= FIRST_DATA) && ({1'b0, idx} < size);
  endfunction

  fcca_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_LIMIT)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  assign s_sum     = SIZE_W'(ciu_r) + SIZE_W'(2);
  assign tbl_size  = (s_sum > SIZE_W'(TABLE_LIMIT)) ? SIZE_W'(TABLE_LIMIT) : s_sum;
  assign start_idx = (ptr_r < FIRST_DATA) ? FIRST_DATA : ptr_r;
  assign issue     = addr_r < tbl_size;
  assign hit       = pend_r && (ram_rdata == '0);
  assign found_inc = found_r + 1'b1;
  assign last_hit  = hit && (found_inc == count_r);
  assign link_ok   = (link_r == '0) || is_legal(link_r, tbl_size);
  assign rd_legal  = is_legal(in_req.read_index, tbl_size);

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    addr_nxt       = addr_r;
    pend_nxt       = 1'b0;
    pidx_nxt       = addr_r[IDX_W-1:0];
    found_nxt      = found_r;
    prev_nxt       = prev_r;
    first_nxt      = first_r;
    count_nxt      = count_r;
    link_nxt       = link_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    ram_we         = 1'b0;
    ram_waddr      = prev_r[ADDR_W-1:0];
    ram_wdata      = '0;
    ram_raddr      = addr_r[ADDR_W-1:0];

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r[ADDR_W-1:0];
        if (addr_r == SIZE_W'(0)) begin
          ram_wdata = FIRST_ENTRY;
        end else if (addr_r == SIZE_W'(1)) begin
          ram_wdata = CHAIN_END_MARK;
        end
        if (addr_r == SIZE_W'(TABLE_LIMIT - 1)) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        ram_raddr = in_req.read_index[ADDR_W-1:0];
        if (in_req.valid) begin
          count_nxt      = in_req.alloc_count;
          link_nxt       = in_req.link_from;
          first_nxt      = '0;
          found_nxt      = '0;
          res_status_nxt = STAT_OK;
          res_entry_nxt  = '0;
          addr_nxt       = SIZE_W'(start_idx);
          if (in_req.command == CMD_READ) begin
            if (rd_legal) begin
              state_nxt = S_RDATA;
            end else begin
              res_status_nxt = STAT_BAD_INDEX;
              state_nxt      = S_DONE;
            end
          end else if (in_req.alloc_count == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN1;
          end
        end
      end

      S_RDATA: begin
        res_entry_nxt = ram_rdata;
        state_nxt     = S_DONE;
      end

      S_SCAN1: begin
        pend_nxt = issue;
        if (issue) begin
          addr_nxt = addr_r + 1'b1;
        end
        if (hit) begin
          found_nxt = found_inc;
        end
        priority if (last_hit) begin
          found_nxt = '0;
          pend_nxt  = 1'b0;
          addr_nxt  = SIZE_W'(start_idx);
          if (link_ok) begin
            state_nxt = S_SCAN2;
          end else begin
            res_status_nxt = STAT_BAD_INDEX;
            state_nxt      = S_DONE;
          end
        end else if (!issue && !pend_r) begin
          res_status_nxt = STAT_NO_SPACE;
          state_nxt      = S_DONE;
        end
      end

      S_SCAN2: begin
        pend_nxt = issue;
        if (issue) begin
          addr_nxt = addr_r + 1'b1;
        end
        if (hit) begin
          found_nxt = found_inc;
          prev_nxt  = pidx_r;
          if (found_r == '0) begin
            first_nxt = pidx_r;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = ENTRY_W'(pidx_r);
          end
          if (last_hit) begin
            state_nxt = S_EOC;
          end
        end
      end

      S_EOC: begin
        ram_we    = 1'b1;
        ram_wdata = CHAIN_END_MARK;
        ptr_nxt   = (prev_r == PTR_MAX) ? PTR_MAX : prev_r + 1'b1;
        state_nxt = (link_r != '0) ? S_LINK : S_DONE;
      end

      S_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = link_r[ADDR_W-1:0];
        ram_wdata = ENTRY_W'(first_r);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  assign out_load      = (state_r == S_DONE) && (!out_valid_r || out_rsp.ready);
  assign out_valid_nxt = out_load || (out_valid_r && !out_rsp.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      pend_r      <= 1'b0;
      ptr_r       <= PTR_RESET;
      ciu_r       <= CIU_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      pend_r      <= pend_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        ciu_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r       <= pidx_nxt;
    found_r      <= found_nxt;
    prev_r       <= prev_nxt;
    first_r      <= first_nxt;
    count_r      <= count_nxt;
    link_r       <= link_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_first_r  <= first_r;
      out_entry_r  <= res_entry_r;
    end
  end

  assign in_req.ready         = (state_r == S_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.head_cluster = out_first_r;
  assign out_rsp.entry_value  = out_entry_r;

endmodule

// File: rtl/fcca_chk.sv
module fcca_chk (
  input logic        clk,
  input logic        rst_n,
  fcca_req_if.sink   in_req,
  fcca_rsp_if.source out_rsp
);
  import fcca_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_req.ready && !out_rsp.valid)
    else $error("ready or valid high right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request taken while previous one still in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && !out_rsp.ready |=> out_rsp.valid && $stable(out_rsp.status)
      && $stable(out_rsp.head_cluster) && $stable(out_rsp.entry_value))
    else $error("stalled response changed");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && (out_rsp.status != STAT_OK)
      |-> (out_rsp.head_cluster == '0) && (out_rsp.entry_value == '0))
    else $error("error response carries data");

endmodule

bind fat32_cluster_chain_allocator fcca_chk u_fcca_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_req (in_req),
  .out_rsp(out_rsp)
);
